// ----- rtl/velocity_command_slew_limiter_top_defines.svh -----
// Assertion macros shared by the slew limiter checker.
`ifndef VELOCITY_COMMAND_SLEW_LIMITER_TOP_DEFINES_SVH
`define VELOCITY_COMMAND_SLEW_LIMITER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VCSL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VCSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked through reset.
`define VCSL_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/vcsl_pkg.sv -----
// Shared types and constants of the velocity command slew limiter.
package vcsl_pkg;

    // Operation codes of an input item.
    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Widths of the configuration port and of the fixed registers.
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int LIM_WIDTH       = 15;
    localparam int IDLE_WIDTH      = 16;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_INVERT_FLAGS      = 3'd0,
        REG_MAX_LINEAR        = 3'd1,
        REG_MAX_ANGULAR       = 3'd2,
        REG_LINEAR_UP_STEP    = 3'd3,
        REG_LINEAR_DOWN_STEP  = 3'd4,
        REG_ANGULAR_UP_STEP   = 3'd5,
        REG_ANGULAR_DOWN_STEP = 3'd6,
        REG_TIMEOUT_TICKS     = 3'd7
    } t_cfg_index;

    // Bits of the invert flags register.
    localparam int INV_LINEAR_BIT  = 0;
    localparam int INV_ANGULAR_BIT = 1;

    // Reset value of the timeout register and saturation of the idle count.
    localparam logic [IDLE_WIDTH-1:0] TIMEOUT_RESET = 16'd10;
    localparam logic [IDLE_WIDTH-1:0] IDLE_MAX      = 16'hFFFF;

    // mrad/s to 1/16 deg/s: multiply by 60079 in Q16 and round half away from zero.
    localparam int                DEG_SHIFT = 16;
    localparam logic [15:0]       DEG_K     = 16'd60079;
    localparam logic [DEG_SHIFT-1:0] DEG_ROUND = 16'h8000;

    // Configuration register set.
    typedef struct packed {
        logic [1:0]            invert_flags;
        logic [LIM_WIDTH-1:0]  max_linear;
        logic [LIM_WIDTH-1:0]  max_angular;
        logic [LIM_WIDTH-1:0]  linear_up_step;
        logic [LIM_WIDTH-1:0]  linear_down_step;
        logic [LIM_WIDTH-1:0]  angular_up_step;
        logic [LIM_WIDTH-1:0]  angular_down_step;
        logic [IDLE_WIDTH-1:0] timeout_ticks;
    } t_cfg;

endpackage

// ----- rtl/vcsl_cfg_regs.sv -----
// Configuration register file of the slew limiter.
module vcsl_cfg_regs (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [vcsl_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [vcsl_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data,
    output vcsl_pkg::t_cfg                        o_cfg
);

    vcsl_pkg::t_cfg r_cfg;
    vcsl_pkg::t_cfg n_cfg;

    // Every write completes in the cycle it is offered.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Decode the register index of a write transfer.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            case (vcsl_pkg::t_cfg_index'(i_cfg_index))
                vcsl_pkg::REG_INVERT_FLAGS: begin
                    n_cfg.invert_flags = i_cfg_data[1:0];
                end
                vcsl_pkg::REG_MAX_LINEAR: begin
                    n_cfg.max_linear = i_cfg_data[vcsl_pkg::LIM_WIDTH-1:0];
                end
                vcsl_pkg::REG_MAX_ANGULAR: begin
                    n_cfg.max_angular = i_cfg_data[vcsl_pkg::LIM_WIDTH-1:0];
                end
                vcsl_pkg::REG_LINEAR_UP_STEP: begin
                    n_cfg.linear_up_step = i_cfg_data[vcsl_pkg::LIM_WIDTH-1:0];
                end
                vcsl_pkg::REG_LINEAR_DOWN_STEP: begin
                    n_cfg.linear_down_step = i_cfg_data[vcsl_pkg::LIM_WIDTH-1:0];
                end
                vcsl_pkg::REG_ANGULAR_UP_STEP: begin
                    n_cfg.angular_up_step = i_cfg_data[vcsl_pkg::LIM_WIDTH-1:0];
                end
                vcsl_pkg::REG_ANGULAR_DOWN_STEP: begin
                    n_cfg.angular_down_step = i_cfg_data[vcsl_pkg::LIM_WIDTH-1:0];
                end
                vcsl_pkg::REG_TIMEOUT_TICKS: begin
                    n_cfg.timeout_ticks = i_cfg_data[vcsl_pkg::IDLE_WIDTH-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    // Register set with its reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.invert_flags      <= '0;
            r_cfg.max_linear        <= '0;
            r_cfg.max_angular       <= '0;
            r_cfg.linear_up_step    <= '0;
            r_cfg.linear_down_step  <= '0;
            r_cfg.angular_up_step   <= '0;
            r_cfg.angular_down_step <= '0;
            r_cfg.timeout_ticks     <= vcsl_pkg::TIMEOUT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- rtl/vcsl_shape.sv -----
// Command shaping for one axis: optional negation and magnitude clamp.
module vcsl_shape #(
    parameter int W = 16
) (
    input  logic signed [W-1:0]                   i_x,
    input  logic                                  i_invert,
    input  logic [vcsl_pkg::LIM_WIDTH-1:0]        i_limit,
    output logic signed [W-1:0]                   o_x
);

    localparam int CW = (W + 1 > vcsl_pkg::LIM_WIDTH + 1) ? W + 1 : vcsl_pkg::LIM_WIDTH + 1;
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0] w_inv;
    logic signed [W:0]   w_ext;
    logic signed [W:0]   w_abs;
    logic [CW-1:0]       w_mag;
    logic [CW-1:0]       w_lim;
    logic signed [W-1:0] w_lim_v;

    always_comb begin
        // Negation saturates the most negative value to the largest positive.
        if (i_invert) begin
            w_inv = (i_x == VMIN) ? VMAX : -i_x;
        end else begin
            w_inv = i_x;
        end

        // Magnitude compared against the limit on a common width.
        w_ext   = {w_inv[W-1], w_inv};
        w_abs   = w_ext[W] ? -w_ext : w_ext;
        w_mag   = CW'($unsigned(w_abs));
        w_lim   = CW'(i_limit);
        w_lim_v = w_lim[W-1:0];

        // A clamp only fires when the limit is below the magnitude, so it fits.
        if ((i_limit != '0) && (w_mag > w_lim)) begin
            o_x = w_inv[W-1] ? -w_lim_v : w_lim_v;
        end else begin
            o_x = w_inv;
        end
    end

endmodule

// ----- rtl/vcsl_deg_conv.sv -----
// Conversion of an angular rate from mrad/s to 1/16 deg/s.
module vcsl_deg_conv #(
    parameter int W = 16
) (
    input  logic signed [W-1:0] i_mrad,
    output logic signed [W-1:0] o_deg16
);

    localparam int PW = W + vcsl_pkg::DEG_SHIFT;

    logic signed [W:0]   w_ext;
    logic [W-1:0]        w_mag;
    logic [PW-1:0]       w_prod;
    logic [W-1:0]        w_round;

    always_comb begin
        // Magnitude, which needs the full width for the most negative value.
        w_ext = {i_mrad[W-1], i_mrad};
        w_mag = i_mrad[W-1] ? W'($unsigned(-w_ext)) : W'($unsigned(w_ext));

        // Scale in Q16, round half away from zero, then restore the sign.
        w_prod  = PW'(w_mag) * PW'(vcsl_pkg::DEG_K) + PW'(vcsl_pkg::DEG_ROUND);
        w_round = w_prod[PW-1:vcsl_pkg::DEG_SHIFT];
        o_deg16 = i_mrad[W-1] ? -$signed(w_round) : $signed(w_round);
    end

endmodule

// ----- rtl/vcsl_slew.sv -----
// One step of the asymmetric slew for one axis.
module vcsl_slew #(
    parameter int W = 16
) (
    input  logic signed [W-1:0]            i_now,
    input  logic signed [W-1:0]            i_target,
    input  logic [vcsl_pkg::LIM_WIDTH-1:0] i_up,
    input  logic [vcsl_pkg::LIM_WIDTH-1:0] i_down,
    output logic signed [W-1:0]            o_next
);

    localparam int CW = (W + 1 > vcsl_pkg::LIM_WIDTH + 1) ? W + 1 : vcsl_pkg::LIM_WIDTH + 1;

    logic signed [W:0] w_now_ext;
    logic signed [W:0] w_tgt_ext;
    logic signed [W:0] w_rise;
    logic signed [W:0] w_fall;
    logic signed [W:0] w_up_s;
    logic signed [W:0] w_down_s;
    logic signed [W:0] w_sum;
    logic signed [W:0] w_diff;

    always_comb begin
        w_now_ext = {i_now[W-1], i_now};
        w_tgt_ext = {i_target[W-1], i_target};
        w_rise    = w_tgt_ext - w_now_ext;
        w_fall    = w_now_ext - w_tgt_ext;

        // A step that is taken is no larger than the gap, so it fits here.
        w_up_s   = $signed((W+1)'(i_up));
        w_down_s = $signed((W+1)'(i_down));
        w_sum    = w_now_ext + w_up_s;
        w_diff   = w_now_ext - w_down_s;

        // Move towards the target, landing on it when the step is zero or would pass it.
        if (i_now < i_target) begin
            if ((i_up == '0) || (CW'($unsigned(w_rise)) < CW'(i_up))) begin
                o_next = i_target;
            end else begin
                o_next = w_sum[W-1:0];
            end
        end else if (i_now > i_target) begin
            if ((i_down == '0) || (CW'($unsigned(w_fall)) < CW'(i_down))) begin
                o_next = i_target;
            end else begin
                o_next = w_diff[W-1:0];
            end
        end else begin
            o_next = i_now;
        end
    end

endmodule

// ----- rtl/velocity_command_slew_limiter_top.sv -----
// A command gives no result and only updates targets and idle count; a tick's result passes
// the input and then the result register. Throughput: one item per cycle unless stalled.
// The input register holds an item while the result register waits on a stalled transfer.
// Synchronous active-low reset clears targets, velocities, idle count and valid flags,
// and returns the configuration registers to their defaults (timeout of ten ticks).
module velocity_command_slew_limiter_top #(
    parameter int VEL_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input channel.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_operation,
    input  logic signed [VEL_WIDTH-1:0]          i_linear_cmd,
    input  logic signed [VEL_WIDTH-1:0]          i_angular_cmd,
    // Result channel.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [VEL_WIDTH-1:0]          o_linear_out,
    output logic signed [VEL_WIDTH-1:0]          o_angular_out,
    // Configuration write channel.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [vcsl_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [vcsl_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    vcsl_pkg::t_cfg w_cfg;

    // Input register.
    logic                        r_in_valid;
    logic                        n_in_valid;
    logic                        r_in_op;
    logic signed [VEL_WIDTH-1:0] r_in_linear;
    logic signed [VEL_WIDTH-1:0] r_in_angular;

    // Block state.
    logic signed [VEL_WIDTH-1:0]     r_lin_target;
    logic signed [VEL_WIDTH-1:0]     n_lin_target;
    logic signed [VEL_WIDTH-1:0]     r_ang_target;
    logic signed [VEL_WIDTH-1:0]     n_ang_target;
    logic signed [VEL_WIDTH-1:0]     r_lin_now;
    logic signed [VEL_WIDTH-1:0]     n_lin_now;
    logic signed [VEL_WIDTH-1:0]     r_ang_now;
    logic signed [VEL_WIDTH-1:0]     n_ang_now;
    logic [vcsl_pkg::IDLE_WIDTH-1:0] r_idle;
    logic [vcsl_pkg::IDLE_WIDTH-1:0] n_idle;

    // Result register.
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic signed [VEL_WIDTH-1:0] r_out_linear;
    logic signed [VEL_WIDTH-1:0] r_out_angular;

    logic                        w_out_free;
    logic                        w_proc;
    logic                        w_in_take;
    logic                        w_timeout;
    logic signed [VEL_WIDTH-1:0] w_lin_shaped;
    logic signed [VEL_WIDTH-1:0] w_ang_shaped;
    logic signed [VEL_WIDTH-1:0] w_ang_deg;
    logic signed [VEL_WIDTH-1:0] w_lin_tgt_eff;
    logic signed [VEL_WIDTH-1:0] w_ang_tgt_eff;
    logic signed [VEL_WIDTH-1:0] w_lin_next;
    logic signed [VEL_WIDTH-1:0] w_ang_next;

    vcsl_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Handshake: the input register drains whenever the result register can take a result.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_proc     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // Command path: shape each axis and convert the angular target.
    vcsl_shape #(.W(VEL_WIDTH)) u_shape_lin (
        .i_x      (r_in_linear),
        .i_invert (w_cfg.invert_flags[vcsl_pkg::INV_LINEAR_BIT]),
        .i_limit  (w_cfg.max_linear),
        .o_x      (w_lin_shaped)
    );

    vcsl_shape #(.W(VEL_WIDTH)) u_shape_ang (
        .i_x      (r_in_angular),
        .i_invert (w_cfg.invert_flags[vcsl_pkg::INV_ANGULAR_BIT]),
        .i_limit  (w_cfg.max_angular),
        .o_x      (w_ang_shaped)
    );

    vcsl_deg_conv #(.W(VEL_WIDTH)) u_deg_conv (
        .i_mrad  (w_ang_shaped),
        .o_deg16 (w_ang_deg)
    );

    // Tick path: targets drop to zero once the idle count reaches the timeout.
    assign w_timeout     = (r_idle >= w_cfg.timeout_ticks);
    assign w_lin_tgt_eff = w_timeout ? '0 : r_lin_target;
    assign w_ang_tgt_eff = w_timeout ? '0 : r_ang_target;

    vcsl_slew #(.W(VEL_WIDTH)) u_slew_lin (
        .i_now    (r_lin_now),
        .i_target (w_lin_tgt_eff),
        .i_up     (w_cfg.linear_up_step),
        .i_down   (w_cfg.linear_down_step),
        .o_next   (w_lin_next)
    );

    vcsl_slew #(.W(VEL_WIDTH)) u_slew_ang (
        .i_now    (r_ang_now),
        .i_target (w_ang_tgt_eff),
        .i_up     (w_cfg.angular_up_step),
        .i_down   (w_cfg.angular_down_step),
        .o_next   (w_ang_next)
    );

    // Next state of the control and state registers.
    always_comb begin
        n_in_valid   = w_in_take ? 1'b1 : (w_proc ? 1'b0 : r_in_valid);
        n_out_valid  = w_out_free ? (w_proc && (r_in_op == vcsl_pkg::OP_TICK)) : r_out_valid;
        n_lin_target = r_lin_target;
        n_ang_target = r_ang_target;
        n_lin_now    = r_lin_now;
        n_ang_now    = r_ang_now;
        n_idle       = r_idle;
        if (w_proc) begin
            if (r_in_op == vcsl_pkg::OP_COMMAND) begin
                n_lin_target = w_lin_shaped;
                n_ang_target = w_ang_deg;
                n_idle       = '0;
            end else begin
                n_lin_target = w_lin_tgt_eff;
                n_ang_target = w_ang_tgt_eff;
                n_lin_now    = w_lin_next;
                n_ang_now    = w_ang_next;
                if (r_idle != vcsl_pkg::IDLE_MAX) begin
                    n_idle = r_idle + 1'b1;
                end
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_lin_target <= '0;
            r_ang_target <= '0;
            r_lin_now    <= '0;
            r_ang_now    <= '0;
            r_idle       <= '0;
        end else begin
            r_in_valid   <= n_in_valid;
            r_out_valid  <= n_out_valid;
            r_lin_target <= n_lin_target;
            r_ang_target <= n_ang_target;
            r_lin_now    <= n_lin_now;
            r_ang_now    <= n_ang_now;
            r_idle       <= n_idle;
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_op      <= i_operation;
            r_in_linear  <= i_linear_cmd;
            r_in_angular <= i_angular_cmd;
        end
        if (w_proc && (r_in_op == vcsl_pkg::OP_TICK)) begin
            r_out_linear  <= w_lin_next;
            r_out_angular <= w_ang_next;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_linear_out  = r_out_linear;
    assign o_angular_out = r_out_angular;

endmodule

// ----- rtl/vcsl_checker.sv -----
// Port-level checker of the slew limiter and its binding to the top level.
`include "velocity_command_slew_limiter_top_defines.svh"

module vcsl_checker #(
    parameter int VEL_WIDTH = 16
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 i_operation,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [VEL_WIDTH-1:0]          o_linear_out,
    input logic signed [VEL_WIDTH-1:0]          o_angular_out
);

    logic w_tick_take;

    assign w_tick_take = i_in_valid && !o_in_stall && (i_operation == vcsl_pkg::OP_TICK);

    // A stalled result keeps its values.
    `VCSL_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_linear_out) && $stable(o_angular_out), "stalled result changed")

    // Reset empties the result register.
    `VCSL_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !o_out_valid, "result valid after reset")

    // The input side stalls only behind a stalled result.
    `VCSL_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall, "input stalled with a free result register")

    // A tick transfer shows a result when the result path is free as the tick leaves the input register.
    `VCSL_ASSERT_NEXT(a_tick_result, w_tick_take ##1 (!o_out_valid || !i_out_stall), o_out_valid, "tick produced no result")

endmodule

bind velocity_command_slew_limiter_top vcsl_checker #(.VEL_WIDTH(VEL_WIDTH)) u_vcsl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_operation   (i_operation),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_linear_out  (o_linear_out),
    .o_angular_out (o_angular_out)
);
